// ===== sv/thbt_pkg.sv =====
// Package for the two-wire handshake byte transceiver.
// Beat payload types, opcodes, register indexes and reset values; no dependencies.
`default_nettype none

package thbt_pkg;

   localparam int TIMEOUT_W = 20;
   localparam int HOLD_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(250000);
   localparam logic [HOLD_W-1:0]    HOLD_RESET    = HOLD_W'(50);
   localparam logic [7:0]           RX_TOP_BIT    = 8'h80;

   localparam logic [1:0] OP_TICK = 2'd0;
   localparam logic [1:0] OP_SEND = 2'd1;
   localparam logic [1:0] OP_RECV = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD    = 1'd1;

   typedef enum logic [5:0] {
      PH_IDLE     = 6'b000001,
      PH_TX_PULL  = 6'b000010,
      PH_TX_REL   = 6'b000100,
      PH_RX_START = 6'b001000,
      PH_RX_HOLD  = 6'b010000,
      PH_RX_ACK   = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] tx_byte;
      logic       tip_level;
      logic       ring_level;
   } req_type;

   typedef struct packed {
      logic       tip_pull_low;
      logic       ring_pull_low;
      logic       busy_res;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       tx_done;
      logic       timeout_error;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/two_wire_handshake_byte_transceiver.sv =====
// Two-wire open-drain (tip/ring) byte transceiver, one beat per line-sample tick.
// Depends on thbt_pkg for payload types, opcodes and register indexes.
// The result beat for a tick is registered and offered in the cycle after the tick is accepted.
// Throughput: one tick per cycle; the state machine advances once per accepted beat.
// The only back-pressure is a full result register that the far side is stalling.
// Reset (synchronous, active high): idle, counters and shift register cleared,
// timeout_ticks = 250000, hold_ticks = 50, result register empty.
`default_nettype none

module two_wire_handshake_byte_transceiver
   import thbt_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request beats: one per tick
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire req_type              req_data,
   // result beats
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      rsp_type              rsp_data,
   // register writes
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [TIMEOUT_W-1:0] csr_data
);

   // configuration
   logic [TIMEOUT_W-1:0] timeout_ticks_ff;
   logic [HOLD_W-1:0]    hold_ticks_ff;

   // transfer state
   phase_type            phase_ff,      phase_in;
   logic [2:0]           bit_index_ff,  bit_index_in;
   logic [7:0]           shift_reg_ff,  shift_reg_in;
   logic [TIMEOUT_W-1:0] wait_count_ff, wait_count_in;
   logic [HOLD_W-1:0]    hold_count_ff, hold_count_in;

   // result register
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff,   rsp_data_in;

   logic                 req_take;

   // wait step helpers
   logic [TIMEOUT_W-1:0] limit;
   logic [TIMEOUT_W-1:0] wait_inc;
   logic                 wait_expired;
   logic [HOLD_W-1:0]    hold_inc;
   logic                 wait_cond;

   // A new tick may enter whenever the result register is empty or draining.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A zero timeout behaves as one: fail at the first failed check.
   assign limit        = (timeout_ticks_ff == '0) ? TIMEOUT_W'(1) : timeout_ticks_ff;
   assign wait_inc     = wait_count_ff + TIMEOUT_W'(1);
   assign wait_expired = (wait_inc >= limit);
   assign hold_inc     = hold_count_ff + HOLD_W'(1);

   // Condition each handshake wait is looking for.
   always_comb begin
      unique case (phase_ff)
         PH_TX_PULL: wait_cond = shift_reg_ff[0] ? !req_data.tip_level : !req_data.ring_level;
         PH_TX_REL:  wait_cond = shift_reg_ff[0] ?  req_data.tip_level :  req_data.ring_level;
         PH_RX_ACK:  wait_cond = (shift_reg_ff & RX_TOP_BIT) != '0 ?
                                 req_data.ring_level : req_data.tip_level;
         default:    wait_cond = 1'b0;
      endcase
   end

   // Next state and result for one tick.
   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      shift_reg_in  = shift_reg_ff;
      wait_count_in = wait_count_ff;
      hold_count_in = hold_count_ff;
      rsp_data_in   = '0;

      unique case (phase_ff)
         PH_TX_PULL, PH_TX_REL, PH_RX_ACK: begin
            if (wait_cond) begin
               wait_count_in = '0;
               if (phase_ff == PH_TX_PULL) begin
                  phase_in = PH_TX_REL;
               end else if (bit_index_ff == 3'd7) begin
                  // last bit handshaken: byte complete
                  phase_in      = PH_IDLE;
                  hold_count_in = '0;
                  if (phase_ff == PH_TX_REL) begin
                     rsp_data_in.tx_done = 1'b1;
                  end else begin
                     rsp_data_in.rx_valid = 1'b1;
                     rsp_data_in.rx_byte  = shift_reg_ff;
                  end
               end else begin
                  bit_index_in = bit_index_ff + 3'd1;
                  if (phase_ff == PH_TX_REL) begin
                     shift_reg_in = shift_reg_ff >> 1;
                     phase_in     = PH_TX_PULL;
                  end else begin
                     phase_in = PH_RX_START;
                  end
               end
            end else if (wait_expired) begin
               // abort: release both lines
               phase_in                  = PH_IDLE;
               wait_count_in             = '0;
               hold_count_in             = '0;
               rsp_data_in.timeout_error = 1'b1;
            end else begin
               wait_count_in = wait_inc;
            end
         end
         PH_RX_START: begin
            // no time limit while both lines idle high
            if (!(req_data.tip_level && req_data.ring_level)) begin
               shift_reg_in  = (shift_reg_ff >> 1) | (req_data.tip_level ? RX_TOP_BIT : 8'h00);
               hold_count_in = '0;
               wait_count_in = '0;
               phase_in      = (hold_ticks_ff == '0) ? PH_RX_ACK : PH_RX_HOLD;
            end
         end
         PH_RX_HOLD: begin
            hold_count_in = hold_inc;
            if (hold_inc >= hold_ticks_ff) begin
               wait_count_in = '0;
               phase_in      = PH_RX_ACK;
            end
         end
         default: begin
            // idle; commands are only taken here
            phase_in = PH_IDLE;
            if (req_data.opcode == OP_SEND) begin
               shift_reg_in  = req_data.tx_byte;
               bit_index_in  = '0;
               wait_count_in = '0;
               phase_in      = PH_TX_PULL;
            end else if (req_data.opcode == OP_RECV) begin
               shift_reg_in  = '0;
               bit_index_in  = '0;
               wait_count_in = '0;
               hold_count_in = '0;
               phase_in      = PH_RX_START;
            end
         end
      endcase

      // Line drive follows the state after this tick.
      if (phase_in == PH_TX_PULL) begin
         rsp_data_in.ring_pull_low = shift_reg_in[0];
         rsp_data_in.tip_pull_low  = !shift_reg_in[0];
      end else if (phase_in == PH_RX_ACK) begin
         rsp_data_in.tip_pull_low  = shift_reg_in[7];
         rsp_data_in.ring_pull_low = !shift_reg_in[7];
      end
      rsp_data_in.busy_res = (phase_in != PH_IDLE);
   end

   // State and result registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_index_ff  <= '0;
         shift_reg_ff  <= '0;
         wait_count_ff <= '0;
         hold_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_take) begin
            phase_ff      <= phase_in;
            bit_index_ff  <= bit_index_in;
            shift_reg_ff  <= shift_reg_in;
            wait_count_ff <= wait_count_in;
            hold_count_ff <= hold_count_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload: loaded with each accepted tick, no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ticks_ff <= TIMEOUT_RESET;
         hold_ticks_ff    <= HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIMEOUT: timeout_ticks_ff <= csr_data;
            CSR_HOLD:    hold_ticks_ff    <= csr_data[HOLD_W-1:0];
            default:     ;
         endcase
      end
   end

endmodule

`default_nettype wire
